[hw/rtl/irc_pkg.sv]
// ----------------------------------------------------------------------------
// irc_pkg
// Shared widths, codes and types of the inode reference count cache.
// ----------------------------------------------------------------------------
package irc_pkg;

  // Field widths
  localparam int DEV_W      = 16;
  localparam int INO_W      = 12;
  localparam int SLOT_IDX_W = 6;
  localparam int STATUS_W   = 3;
  localparam int REFS_W     = 8;
  localparam int SECTOR_W   = 13;
  localparam int OFFSET_W   = 9;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  // Remainder of a division by at most 64 inodes per sector
  localparam int REM_W      = 6;

  // Request commands
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_HIT      = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_ALLOC    = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_INVALID  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_RELEASED = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_REL_ERR  = 3'd5;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 3'd6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAP = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMAP = 8'd1;

  // Disk layout constants
  localparam int unsigned         AREA_BASE  = 2;
  localparam logic [SECTOR_W-1:0] SECTOR_MAX = 13'h1FFF;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX = 9'h1FF;
  localparam logic [REFS_W-1:0]   REFS_MAX   = 8'hFF;

  // One table slot as stored in the slot memory
  typedef struct packed {
    logic [REFS_W-1:0] refs;
    logic [DEV_W-1:0]  device;
    logic [INO_W-1:0]  inode;
  } slot_entry_t;

  // One result as held before it goes out
  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_IDX_W-1:0] slot;
    logic [REFS_W-1:0]     refs;
    logic [SECTOR_W-1:0]   sector;
    logic [OFFSET_W-1:0]   offset;
  } result_t;

endpackage

[hw/rtl/irc_if.sv]
// ----------------------------------------------------------------------------
// irc_if
// Request, response and configuration channels of the inode reference count
// cache, each a valid/ready handshake with its payload.
// ----------------------------------------------------------------------------

// Request channel: get or put
interface irc_req_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic [irc_pkg::DEV_W-1:0]         device;
  logic [irc_pkg::INO_W-1:0]         inode_number;
  logic [irc_pkg::SLOT_IDX_W-1:0]    slot_index;

  modport source (output valid, cmd, device, inode_number, slot_index, input ready);
  modport sink   (input valid, cmd, device, inode_number, slot_index, output ready);
endinterface

// Response channel: one result per request
interface irc_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [irc_pkg::STATUS_W-1:0]      status;
  logic [irc_pkg::SLOT_IDX_W-1:0]    slot;
  logic [irc_pkg::REFS_W-1:0]        ref_count_now;
  logic [irc_pkg::SECTOR_W-1:0]      sector_index;
  logic [irc_pkg::OFFSET_W-1:0]      byte_offset;

  modport source (output valid, status, slot, ref_count_now, sector_index, byte_offset,
                  input ready);
  modport sink   (input valid, status, slot, ref_count_now, sector_index, byte_offset,
                  output ready);
endinterface

// Configuration write channel
interface irc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [irc_pkg::CFG_IDX_W-1:0]     reg_index;
  logic [irc_pkg::CFG_DATA_W-1:0]    wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

[hw/rtl/inode_refcount_cache.sv]
// ----------------------------------------------------------------------------
// inode_refcount_cache
// Table of in-use inode slots with reference counts: get looks up or
// allocates a slot, put releases one.
// ----------------------------------------------------------------------------
// The slot table lives in one memory with a registered read, and requests are
// served one at a time. A get walks the table from slot 0, one memory read per
// cycle, until it hits a matching live slot or reaches the last slot; an
// allocation then waits for the disk location pipeline. A put reads, updates
// and writes back its slot. A get with inode 0 and a put beyond the table are
// answered without a memory read. A finished result sits in an output
// register, so the next request is taken while it waits. No clearing pass
// follows reset.
module inode_refcount_cache #(
  parameter int TABLE_ENTRIES     = 64,
  parameter int INODES_PER_SECTOR = 16,
  parameter int INODE_BYTES       = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  irc_req_if.sink          req_i,
  irc_rsp_if.source        rsp_o,
  irc_cfg_if.sink          cfg_i
);
  import irc_pkg::*;

  localparam int SLOT_W = $clog2(TABLE_ENTRIES);
  localparam logic [SLOT_W-1:0]       LAST_SLOT   = SLOT_W'(TABLE_ENTRIES - 1);
  localparam logic [SLOT_IDX_W+2:0]   ENTRIES_LIM = (SLOT_IDX_W + 3)'(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PUT,
    S_LOCATE,
    S_FIN
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [CFG_DATA_W-1:0] imap_q;
  logic [CFG_DATA_W-1:0] smap_q;

  // Request held during service
  logic [DEV_W-1:0]      req_dev_q;
  logic [INO_W-1:0]      req_ino_q;
  logic [SLOT_IDX_W-1:0] req_slot_q;

  // Scan progress
  logic [SLOT_W-1:0] cnt_q, cnt_d;
  logic [SLOT_W-1:0] free_q, free_d;
  logic              have_free_q, have_free_d;

  // Result staging and output register
  result_t res_q, res_d;
  logic    res_load;
  result_t rsp_q;
  logic    rsp_valid_q;
  logic    rsp_load;

  // Memory and locate unit hookup
  logic              mem_rd_en;
  logic [SLOT_W-1:0] mem_rd_addr;
  slot_entry_t       mem_rd_data;
  logic              mem_wr_en;
  logic [SLOT_W-1:0] mem_wr_addr;
  slot_entry_t       mem_wr_data;
  logic              loc_start;
  logic              loc_done;
  logic [SECTOR_W-1:0] loc_sector;
  logic [OFFSET_W-1:0] loc_offset;

  logic req_fire;
  logic slot_live;
  logic slot_hit;
  logic scan_last;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid & req_i.ready;
  assign cfg_i.ready = 1'b1;

  assign slot_live = (mem_rd_data.refs != '0);
  assign slot_hit  = slot_live && (mem_rd_data.device == req_dev_q)
                     && (mem_rd_data.inode == req_ino_q);
  assign scan_last = (cnt_q == LAST_SLOT);

  irc_slot_ram #(
    .DEPTH (TABLE_ENTRIES)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data)
  );

  irc_locate #(
    .INODES_PER_SECTOR (INODES_PER_SECTOR),
    .INODE_BYTES       (INODE_BYTES)
  ) u_locate (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (loc_start),
    .inode_number_i      (req_ino_q),
    .imap_sector_count_i (imap_q),
    .smap_sector_count_i (smap_q),
    .done_o              (loc_done),
    .sector_index_o      (loc_sector),
    .byte_offset_o       (loc_offset)
  );

  // Sequence each request through read, modify and write back
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    free_d      = free_q;
    have_free_d = have_free_q;
    mem_rd_en   = 1'b0;
    mem_rd_addr = cnt_q + SLOT_W'(1);
    mem_wr_en   = 1'b0;
    mem_wr_addr = cnt_q;
    mem_wr_data = mem_rd_data;
    loc_start   = 1'b0;
    res_load    = 1'b0;
    res_d       = res_q;
    rsp_load    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          res_d.sector = '0;
          res_d.offset = '0;
          res_d.refs   = '0;
          if (req_i.cmd == CMD_PUT) begin
            if ((SLOT_IDX_W + 3)'(req_i.slot_index) >= ENTRIES_LIM) begin
              res_d.status = STAT_REL_ERR;
              res_d.slot   = req_i.slot_index;
              res_load     = 1'b1;
              state_d      = S_FIN;
            end else begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = SLOT_W'(req_i.slot_index);
              state_d     = S_PUT;
            end
          end else if (req_i.inode_number == '0) begin
            res_d.status = STAT_INVALID;
            res_d.slot   = '0;
            res_load     = 1'b1;
            state_d      = S_FIN;
          end else begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = '0;
            cnt_d       = '0;
            have_free_d = 1'b0;
            state_d     = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (slot_hit) begin
          // Bump the first matching live slot, unless it is saturated
          res_d.slot   = SLOT_IDX_W'(cnt_q);
          res_d.sector = '0;
          res_d.offset = '0;
          if (mem_rd_data.refs == REFS_MAX) begin
            res_d.status = STAT_OVERFLOW;
            res_d.refs   = REFS_MAX;
          end else begin
            mem_wr_en        = 1'b1;
            mem_wr_data.refs = mem_rd_data.refs + REFS_W'(1);
            res_d.status     = STAT_HIT;
            res_d.refs       = mem_rd_data.refs + REFS_W'(1);
          end
          res_load = 1'b1;
          state_d  = S_FIN;
        end else if (scan_last) begin
          res_d.sector = '0;
          res_d.offset = '0;
          if (have_free_q || !slot_live) begin
            // Claim the first free slot and look up the record location
            mem_wr_en          = 1'b1;
            mem_wr_addr        = have_free_q ? free_q : cnt_q;
            mem_wr_data.refs   = REFS_W'(1);
            mem_wr_data.device = req_dev_q;
            mem_wr_data.inode  = req_ino_q;
            loc_start          = 1'b1;
            res_d.status       = STAT_ALLOC;
            res_d.slot         = SLOT_IDX_W'(mem_wr_addr);
            res_d.refs         = REFS_W'(1);
            state_d            = S_LOCATE;
          end else begin
            res_d.status = STAT_FULL;
            res_d.slot   = '0;
            res_d.refs   = '0;
            state_d      = S_FIN;
          end
          res_load = 1'b1;
        end else begin
          // Advance to the next slot, remember the first free one
          mem_rd_en = 1'b1;
          cnt_d     = cnt_q + SLOT_W'(1);
          if (!slot_live && !have_free_q) begin
            have_free_d = 1'b1;
            free_d      = cnt_q;
          end
        end
      end

      S_PUT: begin
        res_d.slot   = req_slot_q;
        res_d.sector = '0;
        res_d.offset = '0;
        if (!slot_live) begin
          res_d.status = STAT_REL_ERR;
          res_d.refs   = '0;
        end else begin
          mem_wr_en        = 1'b1;
          mem_wr_addr      = SLOT_W'(req_slot_q);
          mem_wr_data.refs = mem_rd_data.refs - REFS_W'(1);
          res_d.status     = STAT_RELEASED;
          res_d.refs       = mem_rd_data.refs - REFS_W'(1);
        end
        res_load = 1'b1;
        state_d  = S_FIN;
      end

      S_LOCATE: begin
        if (loc_done) begin
          res_d.sector = loc_sector;
          res_d.offset = loc_offset;
          res_load     = 1'b1;
          state_d      = S_FIN;
        end
      end

      S_FIN: begin
        // Hand the result over once the output register is free
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state, scan progress and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      free_q      <= '0;
      have_free_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      free_q      <= free_d;
      have_free_q <= have_free_d;
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Capture request, staged result and output payload
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_dev_q  <= req_i.device;
      req_ino_q  <= req_i.inode_number;
      req_slot_q <= req_i.slot_index;
    end
    if (res_load) begin
      res_q <= res_d;
    end
    if (rsp_load) begin
      rsp_q <= res_q;
    end
  end

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      imap_q <= CFG_DATA_W'(1);
      smap_q <= CFG_DATA_W'(1);
    end else if (cfg_i.valid && cfg_i.ready) begin
      if (cfg_i.reg_index == CFG_IMAP) begin
        imap_q <= cfg_i.wr_data;
      end else if (cfg_i.reg_index == CFG_SMAP) begin
        smap_q <= cfg_i.wr_data;
      end
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = rsp_q.status;
  assign rsp_o.slot          = rsp_q.slot;
  assign rsp_o.ref_count_now = rsp_q.refs;
  assign rsp_o.sector_index  = rsp_q.sector;
  assign rsp_o.byte_offset   = rsp_q.offset;

  // A slot write never lands in the cycle a new request is taken
  a_no_write_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_wr_en |-> !req_fire)
    else $error("slot write while a request is taken");

  // The locate unit only reports back while the allocation waits for it
  a_locate_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loc_done |-> (state_q == S_LOCATE))
    else $error("location result outside the locate wait");

  // A get never writes a free count back
  a_scan_write_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_wr_en && (state_q == S_SCAN)) |-> (mem_wr_data.refs != '0))
    else $error("get wrote a zero count");

  // A new result appears only from the hand-over state
  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == S_FIN))
    else $error("result valid raised outside hand-over");

  // The put update follows directly on taking the request
  a_put_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUT) |-> $past(req_fire))
    else $error("put update without a request taken");

endmodule

[hw/rtl/irc_slot_ram.sv]
// ----------------------------------------------------------------------------
// irc_slot_ram
// Slot memory: one write port, one read port with registered data. A written
// bit per slot makes slots never written since reset read as free.
// ----------------------------------------------------------------------------
module irc_slot_ram #(
  parameter int DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr_i,
  output irc_pkg::slot_entry_t             rd_data_o,
  input  logic                             wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr_i,
  input  irc_pkg::slot_entry_t             wr_data_i
);
  import irc_pkg::*;

  slot_entry_t      mem_q [DEPTH];
  slot_entry_t      rd_word_q;
  logic [DEPTH-1:0] written_q;
  logic             rd_written_q;

  // Write and read the storage array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_word_q <= mem_q[rd_addr_i];
    end
  end

  // Track which slots hold a written word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        written_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_written_q <= written_q[rd_addr_i];
      end
    end
  end

  // Present an unwritten slot as free
  always_comb begin
    rd_data_o      = rd_word_q;
    rd_data_o.refs = rd_written_q ? rd_word_q.refs : '0;
  end

endmodule

[hw/rtl/irc_locate.sv]
// ----------------------------------------------------------------------------
// irc_locate
// Disk location of an inode record: sector and byte offset inside it, from a
// four-stage pipeline with a reciprocal multiply in place of the divide.
// ----------------------------------------------------------------------------
module irc_locate #(
  parameter int INODES_PER_SECTOR = 16,
  parameter int INODE_BYTES       = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [irc_pkg::INO_W-1:0]          inode_number_i,
  input  logic [irc_pkg::CFG_DATA_W-1:0]     imap_sector_count_i,
  input  logic [irc_pkg::CFG_DATA_W-1:0]     smap_sector_count_i,
  output logic                               done_o,
  output logic [irc_pkg::SECTOR_W-1:0]       sector_index_o,
  output logic [irc_pkg::OFFSET_W-1:0]       byte_offset_o
);
  import irc_pkg::*;

  // floor(x / D) == (x * M) >> S for every INO_W-bit x
  localparam int DIV_SH  = INO_W + $clog2(INODES_PER_SECTOR);
  localparam int DIV_MUL = (2 ** DIV_SH + INODES_PER_SECTOR - 1) / INODES_PER_SECTOR;
  localparam int MUL_W   = INO_W + 1;
  localparam int PROD_W  = INO_W + MUL_W;
  localparam int BASE_W  = CFG_DATA_W + 2;
  localparam int SUM_W   = SECTOR_W + 1;
  localparam int OFFP_W  = 2 * (OFFSET_W + 1);

  localparam logic [MUL_W-1:0]  DIV_MUL_C = MUL_W'(DIV_MUL);
  localparam logic [INO_W-1:0]  DIVISOR_C = INO_W'(INODES_PER_SECTOR);
  localparam logic [OFFP_W-1:0] BYTES_C   = OFFP_W'(INODE_BYTES);

  logic [3:0]          stage_v_q;
  logic [INO_W-1:0]    rel_q;
  logic [BASE_W-1:0]   base_q;
  logic [INO_W-1:0]    quot_q;
  logic [REM_W-1:0]    rem_q;
  logic [SECTOR_W-1:0] sector_q;
  logic [OFFSET_W-1:0] offset_q;

  logic [PROD_W-1:0]   quot_prod;
  logic [INO_W-1:0]    quot_back;
  logic [SUM_W-1:0]    sector_sum;
  logic [OFFP_W-1:0]   offset_prod;

  assign quot_prod   = PROD_W'(rel_q) * PROD_W'(DIV_MUL_C);
  assign quot_back   = quot_q * DIVISOR_C;
  assign sector_sum  = SUM_W'(base_q) + SUM_W'(quot_q);
  assign offset_prod = OFFP_W'(rem_q) * BYTES_C;

  // Advance the stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= '0;
    end else begin
      stage_v_q <= {stage_v_q[2:0], start_i};
    end
  end

  // Capture, divide, take remainder and sector, scale offset
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rel_q  <= inode_number_i - INO_W'(1);
      base_q <= BASE_W'(AREA_BASE) + BASE_W'(imap_sector_count_i)
                + BASE_W'(smap_sector_count_i);
    end
    if (stage_v_q[0]) begin
      quot_q <= INO_W'(quot_prod >> DIV_SH);
    end
    if (stage_v_q[1]) begin
      rem_q    <= REM_W'(rel_q - quot_back);
      sector_q <= (sector_sum > SUM_W'(SECTOR_MAX)) ? SECTOR_MAX : SECTOR_W'(sector_sum);
    end
    if (stage_v_q[2]) begin
      offset_q <= (offset_prod > OFFP_W'(OFFSET_MAX)) ? OFFSET_MAX
                                                       : OFFSET_W'(offset_prod);
    end
  end

  assign done_o         = stage_v_q[3];
  assign sector_index_o = sector_q;
  assign byte_offset_o  = offset_q;

endmodule

[tb/inode_refcount_cache_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// inode_refcount_cache_test
// Self-checking bench for the inode reference count cache. A driver sends
// get and put requests in random bursts, a monitor predicts each result from
// a shadow slot table and compares it field by field with the response, and
// the response side stalls on its own pattern. The layout registers are
// changed between phases, while the cache is idle.
// ----------------------------------------------------------------------------
module inode_refcount_cache_test;
  import irc_pkg::*;

  localparam int          TABLE_SLOTS    = 64;
  localparam int          INODES_PER_SEC = 16;
  localparam int          INODE_SIZE     = 32;
  localparam int          POOL_TAGS      = 8;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          DRAIN_CYCLES   = 120;
  localparam int unsigned CYCLE_LIMIT    = 1000000;
  localparam int          MAX_REPORTS    = 10;

  // One request as queued for the driver
  typedef struct packed {
    logic                  cmd;
    logic [DEV_W-1:0]      device;
    logic [INO_W-1:0]      inode;
    logic [SLOT_IDX_W-1:0] slot_index;
  } lookup_req_t;

  typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_STALLS} rx_mode_e;

  logic clk_i;
  logic rst_ni;

  irc_req_if req_if ();
  irc_rsp_if rsp_if ();
  irc_cfg_if cfg_if ();

  inode_refcount_cache #(
    .TABLE_ENTRIES    (TABLE_SLOTS),
    .INODES_PER_SECTOR(INODES_PER_SEC),
    .INODE_BYTES      (INODE_SIZE)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if),
    .cfg_i (cfg_if)
  );

  // Shadow slot table and layout registers
  logic [REFS_W-1:0]     shadow_refs   [TABLE_SLOTS];
  logic [DEV_W-1:0]      shadow_device [TABLE_SLOTS];
  logic [INO_W-1:0]      shadow_inode  [TABLE_SLOTS];
  logic [CFG_DATA_W-1:0] shadow_imap;
  logic [CFG_DATA_W-1:0] shadow_smap;

  lookup_req_t pending_reqs[$];
  result_t     expected_results[$];

  logic [DEV_W-1:0] pool_device [POOL_TAGS];
  logic [INO_W-1:0] pool_inode  [POOL_TAGS];

  int unsigned cycle_count;
  int unsigned mismatch_count;
  logic        req_taken;
  int unsigned burst_left;
  int unsigned gap_left;
  rx_mode_e    rx_mode;
  int unsigned rx_run;
  int unsigned rx_stall_left;
  lookup_req_t next_req;
  result_t     want;

  // Clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Work out the result of one request and advance the shadow table
  function automatic result_t predict_slot_access(lookup_req_t rq);
    result_t     r;
    int          free_idx;
    int unsigned rel;
    int unsigned sector;
    int unsigned offset;
    r        = '0;
    free_idx = -1;
    if (rq.cmd == CMD_PUT) begin
      r.slot = rq.slot_index;
      if (shadow_refs[rq.slot_index] == '0) begin
        r.status = STAT_REL_ERR;
      end else begin
        shadow_refs[rq.slot_index] = shadow_refs[rq.slot_index] - 1'b1;
        r.status = STAT_RELEASED;
        r.refs   = shadow_refs[rq.slot_index];
      end
      return r;
    end
    if (rq.inode == '0) begin
      r.status = STAT_INVALID;
      return r;
    end
    // Lowest live slot with matching tags wins; remember the lowest free one
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (shadow_refs[i] != '0) begin
        if (shadow_device[i] == rq.device && shadow_inode[i] == rq.inode) begin
          r.slot = SLOT_IDX_W'(i);
          if (shadow_refs[i] == REFS_MAX) begin
            r.status = STAT_OVERFLOW;
          end else begin
            shadow_refs[i] = shadow_refs[i] + 1'b1;
            r.status = STAT_HIT;
          end
          r.refs = shadow_refs[i];
          return r;
        end
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (free_idx < 0) begin
      r.status = STAT_FULL;
      return r;
    end
    shadow_device[free_idx] = rq.device;
    shadow_inode[free_idx]  = rq.inode;
    shadow_refs[free_idx]   = 8'd1;
    rel    = int'(rq.inode) - 1;
    sector = AREA_BASE + int'(shadow_imap) + int'(shadow_smap) + rel / INODES_PER_SEC;
    offset = (rel % INODES_PER_SEC) * INODE_SIZE;
    r.status = STAT_ALLOC;
    r.slot   = SLOT_IDX_W'(free_idx);
    r.refs   = 8'd1;
    r.sector = (sector > int'(SECTOR_MAX)) ? SECTOR_MAX : SECTOR_W'(sector);
    r.offset = (offset > int'(OFFSET_MAX)) ? OFFSET_MAX : OFFSET_W'(offset);
    return r;
  endfunction

  // Request driver: bursts of random length with random gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_taken) begin
      req_taken = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
        req_if.valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        next_req = pending_reqs.pop_front();
        req_if.valid        <= 1'b1;
        req_if.cmd          <= next_req.cmd;
        req_if.device       <= next_req.device;
        req_if.inode_number <= next_req.inode;
        req_if.slot_index   <= next_req.slot_index;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Response side: steady, coin-flip or stall stretches
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rx_run == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        rx_run  = $urandom_range(16, 160);
      end
      rx_run--;
      case (rx_mode)
        RX_STEADY: begin
          rsp_if.ready <= 1'b1;
        end
        RX_COIN: begin
          rsp_if.ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          if (rx_stall_left != 0) begin
            rx_stall_left--;
            rsp_if.ready <= 1'b0;
          end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rx_stall_left = $urandom_range(1, 12);
          end
        end
      endcase
    end
  end

  // Monitor: check responses, predict accepted requests, track register writes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        if (rsp_if.valid && rsp_if.ready) begin
          if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("%0t: response with none pending: status %0d slot %0d refs %0d",
                       $realtime, rsp_if.status, rsp_if.slot, rsp_if.ref_count_now);
          end else begin
            want = expected_results.pop_front();
            if (rsp_if.status !== want.status || rsp_if.slot !== want.slot ||
                rsp_if.ref_count_now !== want.refs || rsp_if.sector_index !== want.sector ||
                rsp_if.byte_offset !== want.offset) begin
              mismatch_count++;
              if (mismatch_count <= MAX_REPORTS) begin
                $display("%0t: mismatch: expected status %0d slot %0d refs %0d sector %0d offset %0d",
                         $realtime, want.status, want.slot, want.refs, want.sector,
                         want.offset);
                $display("  got status %0d slot %0d refs %0d sector %0d offset %0d",
                         rsp_if.status, rsp_if.slot, rsp_if.ref_count_now,
                         rsp_if.sector_index, rsp_if.byte_offset);
              end
            end
          end
        end
        if (req_if.valid && req_if.ready) begin
          next_req.cmd        = req_if.cmd;
          next_req.device     = req_if.device;
          next_req.inode      = req_if.inode_number;
          next_req.slot_index = req_if.slot_index;
          expected_results.push_back(predict_slot_access(next_req));
          req_taken = 1'b1;
        end
        if (cfg_if.valid && cfg_if.ready) begin
          case (cfg_if.reg_index)
            CFG_IMAP: shadow_imap = cfg_if.wr_data;
            CFG_SMAP: shadow_smap = cfg_if.wr_data;
            default: ;
          endcase
        end
      end
    end
  end

  // Queue a get; the slot index is don't-care
  task automatic push_get(input logic [DEV_W-1:0] dev, input logic [INO_W-1:0] ino);
    lookup_req_t rq;
    rq.cmd        = CMD_GET;
    rq.device     = dev;
    rq.inode      = ino;
    rq.slot_index = SLOT_IDX_W'($urandom);
    pending_reqs.push_back(rq);
  endtask

  // Queue a put; device and inode are don't-care
  task automatic push_put(input logic [SLOT_IDX_W-1:0] idx);
    lookup_req_t rq;
    rq.cmd        = CMD_PUT;
    rq.device     = DEV_W'($urandom);
    rq.inode      = INO_W'($urandom);
    rq.slot_index = idx;
    pending_reqs.push_back(rq);
  endtask

  // Draw a small tag set with shared devices and shared inode numbers
  task automatic refresh_pool();
    logic [DEV_W-1:0] dev_shared;
    logic [INO_W-1:0] ino_shared;
    dev_shared = DEV_W'($urandom);
    ino_shared = INO_W'($urandom_range(1, 4095));
    for (int i = 0; i < POOL_TAGS; i++) begin
      pool_device[i] = (i < POOL_TAGS / 2) ? dev_shared : DEV_W'($urandom);
      pool_inode[i]  = (i % 2 == 1) ? ino_shared : INO_W'($urandom_range(1, 4095));
    end
  endtask

  // Mostly gets on the tag set and puts on low slots, some random noise
  task automatic push_random_mix(input int unsigned count);
    int unsigned pick;
    int unsigned tag;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      tag  = $urandom_range(0, POOL_TAGS - 1);
      if (pick < 52) begin
        push_get(pool_device[tag], pool_inode[tag]);
      end else if (pick < 90) begin
        push_put(SLOT_IDX_W'($urandom_range(0, 23)));
      end else if (pick < 95) begin
        push_put(SLOT_IDX_W'($urandom));
      end else begin
        push_get(DEV_W'($urandom),
                 ($urandom_range(0, 2) == 0) ? INO_W'(0) : INO_W'($urandom));
      end
    end
  endtask

  // Write one layout register through its handshake
  task automatic write_layout_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wr_data   <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Hold until every queued request is taken and answered
  task automatic wait_idle(input int unsigned settle);
    while (pending_reqs.size() != 0 || req_if.valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic set_layout(input logic [CFG_DATA_W-1:0] imap,
                            input logic [CFG_DATA_W-1:0] smap);
    wait_idle(SETTLE_CYCLES);
    write_layout_reg(CFG_IMAP, imap);
    write_layout_reg(CFG_SMAP, smap);
  endtask

  // Stimulus and end of run
  initial begin
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.cmd          = CMD_GET;
    req_if.device       = '0;
    req_if.inode_number = '0;
    req_if.slot_index   = '0;
    rsp_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.reg_index    = CFG_IMAP;
    cfg_if.wr_data      = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      shadow_refs[i]   = '0;
      shadow_device[i] = '0;
      shadow_inode[i]  = '0;
    end
    shadow_imap    = 8'd1;
    shadow_smap    = 8'd1;
    cycle_count    = 0;
    mismatch_count = 0;
    req_taken      = 1'b0;
    burst_left     = 0;
    gap_left       = 0;
    rx_mode        = RX_STEADY;
    rx_run         = 0;
    rx_stall_left  = 0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Saturate slot 0 at the count limit, then step it down and back up
    for (int i = 0; i < 257; i++) push_get(16'h5A5A, 12'h800);
    push_put(6'd0);
    push_get(16'h5A5A, 12'h800);
    push_get(16'h5A5A, 12'h800);

    // Directed: invalid inode, field extremes, sector edges, hits and releases
    push_get(16'h0000, 12'h000);
    push_get(16'hFFFF, 12'h000);
    push_get(16'h0000, 12'h001);
    push_get(16'hFFFF, 12'hFFF);
    push_get(16'h0000, 12'h010);
    push_get(16'h0000, 12'h011);
    push_get(16'hFFFF, 12'hFFF);
    push_get(16'h0000, 12'h001);
    push_get(16'h0001, 12'h001);
    push_get(16'h0000, 12'h002);
    push_put(6'd1);
    push_put(6'd1);
    push_put(6'd1);
    push_put(6'd63);
    push_get(16'h0000, 12'h001);
    push_put(6'd1);
    push_get(16'h8000, 12'h800);
    push_put(6'd2);
    push_get(16'hFFFF, 12'hFFF);
    push_get(16'h0000, 12'h001);

    // Layout at its floor
    set_layout(8'd0, 8'd0);
    refresh_pool();
    push_random_mix(250);

    // Layout at its ceiling
    set_layout(8'd255, 8'd255);
    refresh_pool();
    push_random_mix(250);

    // Random layout, with the sender held until all responses are back midway
    set_layout(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
    refresh_pool();
    push_random_mix(150);
    wait_idle(0);
    push_random_mix(150);

    // Mixed extremes
    set_layout(8'd0, 8'd255);
    refresh_pool();
    push_random_mix(300);

    // Fill the table, hit it full, free one slot and claim it again
    set_layout(8'd255, 8'd0);
    for (int i = 0; i < 70; i++) push_get(DEV_W'(16'hC000 + i), INO_W'(i + 1));
    push_get(16'hC000, 12'h001);
    push_get(16'hC045, 12'h046);
    push_put(6'd63);
    push_get(16'hBEEF, 12'h123);
    push_get(16'hBEEF, 12'h123);
    push_get(16'hBEEE, 12'h124);

    wait_idle(DRAIN_CYCLES);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/irc_pkg.sv
hw/rtl/irc_if.sv
hw/rtl/irc_slot_ram.sv
hw/rtl/irc_locate.sv
hw/rtl/inode_refcount_cache.sv
tb/inode_refcount_cache_test.sv
